// File: hw/rtl/fnte_pkg.sv
// fnte_pkg: shared types, codes and constants of the forward ntt engine
// no dependencies
`default_nettype none
package fnte_pkg;

  localparam int DW   = 31;  // coefficient, modulus and root width
  localparam int LGW  = 4;   // width of log_size and stage counters
  localparam int IDXW = 8;   // index field width
  localparam int OPW  = 2;   // operation field width
  localparam int CFGW = 2;   // configuration index width

  localparam int LOG_N_MAX_DEF  = 8;
  localparam int COEFF_BITS_DEF = 31;

  localparam logic [DW-1:0]  MODULUS_RST  = DW'(3329);
  localparam logic [DW-1:0]  ROOT_RST     = DW'(17);
  localparam logic [LGW-1:0] LOG_SIZE_RST = LGW'(8);

  localparam logic [CFGW-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFGW-1:0] CFG_ROOT     = 2'd1;
  localparam logic [CFGW-1:0] CFG_LOG_SIZE = 2'd2;

  typedef enum logic [OPW-1:0] {
    OP_LOAD  = 2'd0,
    OP_XFORM = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_WAIT,
    ST_LD_WRITE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_TW_ROOT,
    ST_TW_WRITE,
    ST_TW_WAIT,
    ST_BF_RDA,
    ST_BF_RDB,
    ST_BF_CAPB,
    ST_BF_WAIT_A,
    ST_BF_WAIT_T,
    ST_BF_WRA,
    ST_BF_WRB,
    ST_DONE
  } state_t;

  // request to the shared modular multiplier
  typedef struct packed {
    logic          start;
    logic [DW-1:0] a;    // multiplicand, below the modulus
    logic [DW-1:0] b;    // multiplier, any value, scanned msb first
  } mul_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/fnte_ram.sv
// fnte_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module fnte_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/fnte_modmul.sv
// fnte_modmul: bit-serial modular multiplier, (a * b) mod q, one multiplier bit a cycle
// depends on fnte_pkg
`default_nettype none
module fnte_modmul (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire fnte_pkg::mul_req_t    req,
  input  wire logic [fnte_pkg::DW-1:0] q,
  output logic                       done,
  output logic [fnte_pkg::DW-1:0]    result
);

  localparam int DW = fnte_pkg::DW;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] a_r;
  logic [DW-1:0] b_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   dbl;
  logic [DW:0]   dbl_red;
  logic [DW:0]   sum;
  logic [DW:0]   sum_red;

  // acc stays below q: double, reduce, add, reduce
  always_comb begin
    dbl     = {result, 1'b0};
    dbl_red = (dbl >= {1'b0, q}) ? dbl - {1'b0, q} : dbl;
    sum     = dbl_red + (b_r[DW-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, q}) ? sum - {1'b0, q} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r    <= req.a;
      b_r    <= req.b;
      result <= '0;
    end else if (busy) begin
      b_r    <= {b_r[DW-2:0], 1'b0};
      result <= sum_red[DW-1:0];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/forward_ntt_engine_unit.sv
// forward_ntt_engine_unit: top level, sequencer of loads, reads and the in-place ntt
// depends on fnte_pkg, fnte_ram, fnte_modmul
//
// channel   dir  contents
// s_*       in   tdata: operation[1:0], index[9:2], coefficient[40:10], zero pad
// m_*       out  tdata: read_value[30:0], index_error[31]
// cfg_*     in   write: 0 modulus, 1 root, 2 log_size
//
// loads and transforms go through one bit-serial modular multiplier; reads do not.
// a transform first computes n twiddles, then runs the (n/2)*log2(n) butterflies.
// after reset all 2^LOG_N_MAX entries of the coefficient store are cleared, s_tready low.
// a finished result waits in the output register while the next transaction runs.
`default_nettype none
module forward_ntt_engine_unit #(
  parameter int LOG_N_MAX  = fnte_pkg::LOG_N_MAX_DEF,
  parameter int COEFF_BITS = fnte_pkg::COEFF_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [47:0]               s_tdata,   // operation, index, coefficient
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [31:0]                    m_tdata,   // read_value, index_error
  input  wire logic                      cfg_we,
  input  wire logic [fnte_pkg::CFGW-1:0] cfg_index,
  input  wire logic [fnte_pkg::DW-1:0]   cfg_data
);

  localparam int DW   = fnte_pkg::DW;
  localparam int LGW  = fnte_pkg::LGW;
  localparam int AW   = LOG_N_MAX;
  localparam int NW   = AW + 1;
  localparam int CMPW = AW + fnte_pkg::IDXW + 1;
  localparam int DEPTH = 1 << AW;
  localparam logic [DW-1:0] CMASK = DW'((64'd1 << COEFF_BITS) - 64'd1);

  fnte_pkg::state_t state, state_next;

  logic [DW-1:0]  modulus, root;
  logic [LGW-1:0] log_size;
  logic [DW-1:0]  q;
  logic [LGW-1:0] lg;
  logic [NW-1:0]  n_val;

  // input fields
  logic [fnte_pkg::OPW-1:0]  in_op;
  logic [fnte_pkg::IDXW-1:0] in_idx;
  logic [DW-1:0]             in_coef;
  logic                      in_range;

  // work registers
  logic [AW-1:0]  idx;
  logic [DW-1:0]  res_val;
  logic           res_err;
  logic [DW-1:0]  rr;     // reduced root
  logic [DW-1:0]  pw;     // running root power
  logic [AW-1:0]  ecnt;
  logic [AW-1:0]  bcnt;
  logic [LGW-1:0] stage;
  logic [DW-1:0]  av, bv, wv, ar;

  // address arithmetic
  logic [AW-1:0] len_bit, len_mask, j_lo, j_hi, k_tw, rev_e, tw_waddr;
  logic [AW-1:0] clr_cnt;

  // memories
  logic          c_we, t_we;
  logic [AW-1:0] c_waddr, c_raddr, t_raddr;
  logic [DW-1:0] c_wdata, c_rdata, t_rdata;

  fnte_pkg::mul_req_t mreq;
  logic               mdone;
  logic [DW-1:0]      mres;

  // butterfly result
  logic [DW:0]   bf_sum, bf_sum_red, bf_dif, bf_dif_red;

  assign in_op   = s_tdata[1:0];
  assign in_idx  = s_tdata[9:2];
  assign in_coef = s_tdata[40:10] & CMASK;

  assign q     = (modulus < DW'(2)) ? DW'(2) : modulus;
  assign lg    = (log_size == '0) ? LGW'(1) :
                 (log_size > LGW'(LOG_N_MAX)) ? LGW'(LOG_N_MAX) : log_size;
  assign n_val = NW'(1) << lg;
  assign in_range = CMPW'(in_idx) < CMPW'(n_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= fnte_pkg::MODULUS_RST;
      root     <= fnte_pkg::ROOT_RST;
      log_size <= fnte_pkg::LOG_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fnte_pkg::CFG_MODULUS:  modulus  <= cfg_data;
        fnte_pkg::CFG_ROOT:     root     <= cfg_data;
        fnte_pkg::CFG_LOG_SIZE: log_size <= cfg_data[LGW-1:0];
        default: ;
      endcase
    end
  end

  // butterfly j, j+len and twiddle index k from the butterfly count
  assign len_bit  = AW'(1) << stage;
  assign len_mask = len_bit - AW'(1);
  assign j_lo     = AW'((bcnt >> stage) << (stage + LGW'(1))) | (bcnt & len_mask);
  assign j_hi     = j_lo | len_bit;
  assign k_tw     = (AW'(1) << (lg - LGW'(1) - stage)) | (bcnt >> stage);

  for (genvar gi = 0; gi < AW; gi++) begin : g_rev
    assign rev_e[gi] = ecnt[AW-1-gi];
  end
  assign tw_waddr = rev_e >> (LGW'(AW) - lg);

  assign bf_sum     = {1'b0, ar} + {1'b0, mres};
  assign bf_sum_red = (bf_sum >= {1'b0, q}) ? bf_sum - {1'b0, q} : bf_sum;
  assign bf_dif     = {1'b0, ar} - {1'b0, mres};
  assign bf_dif_red = bf_dif[DW] ? bf_dif + {1'b0, q} : bf_dif;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fnte_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mreq       = '0;
    c_we       = 1'b0;
    c_waddr    = idx;
    c_wdata    = '0;
    c_raddr    = j_lo;
    t_we       = 1'b0;
    t_raddr    = k_tw;
    case (state)
      fnte_pkg::ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_cnt;
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = fnte_pkg::ST_IDLE;
        end
      end
      fnte_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        mreq.a   = DW'(1);
        mreq.b   = in_coef;
        if (s_tvalid) begin
          case (in_op)
            fnte_pkg::OP_LOAD: begin
              if (in_range) begin
                mreq.start = 1'b1;
                state_next = fnte_pkg::ST_LD_WAIT;
              end else begin
                state_next = fnte_pkg::ST_DONE;
              end
            end
            fnte_pkg::OP_READ: begin
              state_next = in_range ? fnte_pkg::ST_RD_ADDR : fnte_pkg::ST_DONE;
            end
            fnte_pkg::OP_XFORM: begin
              mreq.b     = root;
              mreq.start = 1'b1;
              state_next = fnte_pkg::ST_TW_ROOT;
            end
            default: state_next = fnte_pkg::ST_DONE;
          endcase
        end
      end
      fnte_pkg::ST_LD_WAIT: begin
        if (mdone) begin
          state_next = fnte_pkg::ST_LD_WRITE;
        end
      end
      fnte_pkg::ST_LD_WRITE: begin
        c_we       = 1'b1;
        c_wdata    = ar;
        state_next = fnte_pkg::ST_DONE;
      end
      fnte_pkg::ST_RD_ADDR: begin
        c_raddr    = idx;
        state_next = fnte_pkg::ST_RD_DATA;
      end
      fnte_pkg::ST_RD_DATA: begin
        state_next = fnte_pkg::ST_DONE;
      end
      fnte_pkg::ST_TW_ROOT: begin
        if (mdone) begin
          state_next = fnte_pkg::ST_TW_WRITE;
        end
      end
      fnte_pkg::ST_TW_WRITE: begin
        t_we   = 1'b1;
        mreq.a = pw;
        mreq.b = rr;
        if (ecnt == AW'(n_val - NW'(1))) begin
          state_next = fnte_pkg::ST_BF_RDA;
        end else begin
          mreq.start = 1'b1;
          state_next = fnte_pkg::ST_TW_WAIT;
        end
      end
      fnte_pkg::ST_TW_WAIT: begin
        if (mdone) begin
          state_next = fnte_pkg::ST_TW_WRITE;
        end
      end
      fnte_pkg::ST_BF_RDA: begin
        state_next = fnte_pkg::ST_BF_RDB;
      end
      fnte_pkg::ST_BF_RDB: begin
        c_raddr    = j_hi;
        state_next = fnte_pkg::ST_BF_CAPB;
      end
      fnte_pkg::ST_BF_CAPB: begin
        mreq.start = 1'b1;
        mreq.a     = DW'(1);
        mreq.b     = av;
        state_next = fnte_pkg::ST_BF_WAIT_A;
      end
      fnte_pkg::ST_BF_WAIT_A: begin
        mreq.a = wv;
        mreq.b = bv;
        if (mdone) begin
          mreq.start = 1'b1;
          state_next = fnte_pkg::ST_BF_WAIT_T;
        end
      end
      fnte_pkg::ST_BF_WAIT_T: begin
        if (mdone) begin
          state_next = fnte_pkg::ST_BF_WRA;
        end
      end
      fnte_pkg::ST_BF_WRA: begin
        c_we       = 1'b1;
        c_waddr    = j_lo;
        c_wdata    = bf_sum_red[DW-1:0];
        state_next = fnte_pkg::ST_BF_WRB;
      end
      fnte_pkg::ST_BF_WRB: begin
        c_we    = 1'b1;
        c_waddr = j_hi;
        c_wdata = bf_dif_red[DW-1:0];
        if (NW'(bcnt) == (n_val >> 1) - NW'(1) && stage == '0) begin
          state_next = fnte_pkg::ST_DONE;
        end else begin
          state_next = fnte_pkg::ST_BF_RDA;
        end
      end
      fnte_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = fnte_pkg::ST_IDLE;
        end
      end
      default: state_next = fnte_pkg::ST_IDLE;
    endcase
  end

  // work registers
  always_ff @(posedge clk) begin
    case (state)
      fnte_pkg::ST_IDLE: begin
        idx     <= AW'(in_idx);
        res_val <= '0;
        res_err <= (in_op == fnte_pkg::OP_LOAD || in_op == fnte_pkg::OP_READ) && !in_range;
        pw      <= DW'(1);
        ecnt    <= '0;
        bcnt    <= '0;
        stage   <= lg - LGW'(1);
      end
      fnte_pkg::ST_LD_WAIT: begin
        ar <= mres;
      end
      fnte_pkg::ST_RD_DATA: begin
        res_val <= c_rdata;
      end
      fnte_pkg::ST_TW_ROOT: begin
        rr <= mres;
      end
      fnte_pkg::ST_TW_WRITE: begin
        ecnt <= ecnt + AW'(1);
      end
      fnte_pkg::ST_TW_WAIT: begin
        pw <= mres;
      end
      fnte_pkg::ST_BF_RDB: begin
        av <= c_rdata;
        wv <= t_rdata;
      end
      fnte_pkg::ST_BF_CAPB: begin
        bv <= c_rdata;
      end
      fnte_pkg::ST_BF_WAIT_A: begin
        ar <= mres;
      end
      fnte_pkg::ST_BF_WRB: begin
        if (NW'(bcnt) == (n_val >> 1) - NW'(1)) begin
          bcnt  <= '0;
          stage <= stage - LGW'(1);
        end else begin
          bcnt <= bcnt + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == fnte_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == fnte_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fnte_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_err, res_val};
    end
  end

  fnte_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  fnte_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_twid_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (tw_waddr),
    .wdata (pw),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  fnte_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .q      (q),
    .done   (mdone),
    .result (mres)
  );

endmodule
`default_nettype wire
